/* rtl/perm_unrk_pkg.sv */
package perm_unrk_pkg;

   localparam int RANK_W   = 62;
   localparam int SIZE_W   = 5;
   localparam int ELEM_W   = 5;
   localparam int STATUS_W = 2;
   localparam int BITS_W   = 3;
   // rank widened to hold the weight shifted by up to four places
   localparam int TRIAL_W  = RANK_W + 4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic start;
      logic step;
      logic emit_elem;
      logic emit_special;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bad;
      logic empty;
      logic bits_zero;
      logic step_last;
      logic final_elem;
      logic out_free;
   } stat_type;

   // factorial weights, 0! to 20!
   function automatic logic [RANK_W-1:0] fact(input logic [SIZE_W-1:0] idx);
      logic [RANK_W-1:0] f;
      unique case (idx)
         5'd0:    f = 62'd1;
         5'd1:    f = 62'd1;
         5'd2:    f = 62'd2;
         5'd3:    f = 62'd6;
         5'd4:    f = 62'd24;
         5'd5:    f = 62'd120;
         5'd6:    f = 62'd720;
         5'd7:    f = 62'd5040;
         5'd8:    f = 62'd40320;
         5'd9:    f = 62'd362880;
         5'd10:   f = 62'd3628800;
         5'd11:   f = 62'd39916800;
         5'd12:   f = 62'd479001600;
         5'd13:   f = 62'd6227020800;
         5'd14:   f = 62'd87178291200;
         5'd15:   f = 62'd1307674368000;
         5'd16:   f = 62'd20922789888000;
         5'd17:   f = 62'd355687428096000;
         5'd18:   f = 62'd6402373705728000;
         5'd19:   f = 62'd121645100408832000;
         5'd20:   f = 62'd2432902008176640000;
         default: f = '1;
      endcase
      return f;
   endfunction

   // number of digit bits needed while r elements remain (digit below r)
   function automatic logic [BITS_W-1:0] digit_bits(input logic [SIZE_W-1:0] r);
      logic [BITS_W-1:0] b;
      if (r > 5'd16) begin
         b = 3'd5;
      end else if (r > 5'd8) begin
         b = 3'd4;
      end else if (r > 5'd4) begin
         b = 3'd3;
      end else if (r > 5'd2) begin
         b = 3'd2;
      end else if (r > 5'd1) begin
         b = 3'd1;
      end else begin
         b = 3'd0;
      end
      return b;
   endfunction

endpackage

/* rtl/perm_unrk_if.sv */
interface perm_unrk_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [perm_unrk_pkg::RANK_W-1:0]     rank;
   logic [perm_unrk_pkg::SIZE_W-1:0]     size;

   modport source (output valid, output rank, output size, input ready);
   modport sink   (input valid, input rank, input size, output ready);
endinterface

interface perm_unrk_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [perm_unrk_pkg::ELEM_W-1:0]     element;
   logic                                 last;
   logic [perm_unrk_pkg::STATUS_W-1:0]   status;

   modport source (output valid, output element, output last, output status, input ready);
   modport sink   (input valid, input element, input last, input status, output ready);
endinterface

/* rtl/permutation_unrank.sv */
// Lexicographic permutation unranking. Each request transaction carries a size n and a
// rank; the block returns the rank-th permutation of 0..n-1 as n response transactions,
// leftmost element first, with last set on the final one. A size above MAX_SIZE or a
// rank at or above n! gives a single response with status 2; size 0 with rank 0 gives
// a single response with status 1. One request is handled at a time. The rank is
// decoded in the factorial number system by one shared restoring-division step, one
// digit bit per cycle; each element's digit is decoded and then emitted, the emit waiting
// while the consumer stalls. A new request is accepted while the last response waits.
module permutation_unrank #(
   parameter int MAX_SIZE = 20
) (
   input logic              clock,
   input logic              reset,
   perm_unrk_req_if.sink    req,
   perm_unrk_rsp_if.source  rsp
);
   import perm_unrk_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   perm_unrk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // digit extraction, element pool and response register
   perm_unrk_dp #(
      .MAX_SIZE (MAX_SIZE)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_rank (req.rank),
      .req_size (req.size),
      .cmd      (cmd),
      .stat     (stat),
      .rsp      (rsp)
   );

endmodule

/* rtl/perm_unrk_ctrl.sv */
module perm_unrk_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  perm_unrk_pkg::stat_type stat,
   output perm_unrk_pkg::cmd_type  cmd
);
   import perm_unrk_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CHECK  = 2'd1;
   localparam logic [1:0] S_DIVIDE = 2'd2;
   localparam logic [1:0] S_EMIT   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.bad || stat.empty) begin
               if (stat.out_free) begin
                  cmd.emit_special = 1'b1;
                  state_in         = S_IDLE;
               end
            end else begin
               cmd.start = 1'b1;
               state_in  = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (stat.bits_zero) begin
               state_in = S_EMIT;
            end else begin
               cmd.step = 1'b1;
               if (stat.step_last) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_elem = 1'b1;
               state_in      = stat.final_elem ? S_IDLE : S_DIVIDE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/perm_unrk_dp.sv */
module perm_unrk_dp #(
   parameter int MAX_SIZE = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [perm_unrk_pkg::RANK_W-1:0]      req_rank,
   input  logic [perm_unrk_pkg::SIZE_W-1:0]      req_size,
   input  perm_unrk_pkg::cmd_type                cmd,
   output perm_unrk_pkg::stat_type               stat,
   perm_unrk_rsp_if.source                       rsp
);
   import perm_unrk_pkg::*;

   localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

   logic [RANK_W-1:0]   rank_ff, rank_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [SIZE_W-1:0]   remaining_ff, remaining_in;
   logic [BITS_W-1:0]   bitcnt_ff, bitcnt_in;
   logic [ELEM_W-1:0]   digit_ff, digit_in;
   logic [RANK_W-1:0]   weight_ff, weight_in;
   logic [ELEM_W-1:0]   pool_ff [MAX_SIZE];
   logic [ELEM_W-1:0]   pool_in [MAX_SIZE];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0]   elem_ff, elem_in;
   logic                last_ff, last_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic [BITS_W-1:0]   shift;
   logic [TRIAL_W-1:0]  trial;
   logic [TRIAL_W-1:0]  rank_ext;
   logic                fits;
   logic [SIZE_W-1:0]   rem_dec;
   logic [ELEM_W-1:0]   pick;

   // one restoring division step against the shifted weight
   assign shift    = bitcnt_ff - 3'd1;
   assign trial    = TRIAL_W'(weight_ff) << shift;
   assign rank_ext = TRIAL_W'(rank_ff);
   assign fits     = (rank_ext >= trial);
   assign rem_dec  = remaining_ff - 5'd1;
   assign pick     = pool_ff[digit_ff[IDX_W-1:0]];

   // status toward the controller
   always_comb begin
      stat.bad        = (size_ff > SIZE_W'(MAX_SIZE)) || (rank_ff >= fact(size_ff));
      stat.empty      = (size_ff == '0);
      stat.bits_zero  = (bitcnt_ff == '0);
      stat.step_last  = (bitcnt_ff == 3'd1);
      stat.final_elem = (remaining_ff == 5'd1);
      stat.out_free   = !rsp_valid_ff || rsp.ready;
   end

   // working registers
   always_comb begin
      rank_in      = rank_ff;
      size_in      = size_ff;
      remaining_in = remaining_ff;
      bitcnt_in    = bitcnt_ff;
      digit_in     = digit_ff;
      weight_in    = weight_ff;
      pool_in      = pool_ff;
      if (cmd.load) begin
         rank_in = req_rank;
         size_in = req_size;
         for (int i = 0; i < MAX_SIZE; i++) begin
            pool_in[i] = ELEM_W'(i);
         end
      end
      if (cmd.start) begin
         remaining_in = size_ff;
         bitcnt_in    = digit_bits(size_ff);
         digit_in     = '0;
         weight_in    = fact(size_ff - 5'd1);
      end
      if (cmd.step) begin
         bitcnt_in = bitcnt_ff - 3'd1;
         if (fits) begin
            rank_in  = RANK_W'(rank_ext - trial);
            digit_in = digit_ff | (ELEM_W'(1) << shift);
         end
      end
      // remove the picked element and close the gap
      if (cmd.emit_elem) begin
         remaining_in = rem_dec;
         bitcnt_in    = digit_bits(rem_dec);
         digit_in     = '0;
         weight_in    = fact(rem_dec - 5'd1);
         for (int i = 0; i < MAX_SIZE - 1; i++) begin
            if (ELEM_W'(i) >= digit_ff) begin
               pool_in[i] = pool_ff[i+1];
            end
         end
      end
   end

   // output register
   always_comb begin
      elem_in   = elem_ff;
      last_in   = last_ff;
      status_in = status_ff;
      if (cmd.emit_elem) begin
         rsp_valid_in = 1'b1;
         elem_in      = pick;
         last_in      = stat.final_elem;
         status_in    = ST_OK;
      end else if (cmd.emit_special) begin
         rsp_valid_in = 1'b1;
         elem_in      = '0;
         last_in      = 1'b1;
         status_in    = stat.bad ? ST_RANGE : ST_EMPTY;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rank_ff      <= rank_in;
      size_ff      <= size_in;
      remaining_ff <= remaining_in;
      bitcnt_ff    <= bitcnt_in;
      digit_ff     <= digit_in;
      weight_ff    <= weight_in;
      pool_ff      <= pool_in;
      elem_ff      <= elem_in;
      last_ff      <= last_in;
      status_ff    <= status_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.element = elem_ff;
   assign rsp.last    = last_ff;
   assign rsp.status  = status_ff;

endmodule

/* tb/sv/permutation_unrank_checker.sv */
module permutation_unrank_checker #(
   parameter int MAX_SIZE = 20
) (
   input  logic      clock,
   input  logic      reset,
   perm_unrk_req_if  req,
   perm_unrk_rsp_if  rsp,
   output int        fail_count,
   output int        pending,
   output int        results_seen,
   output int        special_seen
);
   import perm_unrk_pkg::*;

   typedef struct packed {
      logic [ELEM_W-1:0]   element;
      logic                last;
      logic [STATUS_W-1:0] status;
   } perm_result_type;

   // expected responses still owed by the block, oldest first
   perm_result_type awaited_q[$];
   int failures = 0;
   int checked  = 0;
   int specials = 0;

   function automatic logic [63:0] factorial(input int n);
      logic [63:0] f;
      f = 64'd1;
      for (int k = 2; k <= n; k++) begin
         f = f * 64'(k);
      end
      return f;
   endfunction

   function automatic void push_result(input logic [ELEM_W-1:0] element, input logic last,
                                       input logic [STATUS_W-1:0] status);
      perm_result_type r;
      r.element = element;
      r.last    = last;
      r.status  = status;
      awaited_q = {awaited_q, r};
   endfunction

   // factorial number system decode: each digit picks from the ascending pool
   function automatic void unrank_into(input logic [RANK_W-1:0] rank,
                                       input logic [SIZE_W-1:0] size);
      logic [ELEM_W-1:0] pool [0:19];
      logic [63:0]       rest;
      logic [63:0]       weight;
      logic [63:0]       digit;
      int                remaining;
      int                pick;
      if (int'(size) > MAX_SIZE) begin
         push_result('0, 1'b1, ST_RANGE);
      end else if ({2'b00, rank} >= factorial(int'(size))) begin
         push_result('0, 1'b1, ST_RANGE);
      end else if (size == '0) begin
         push_result('0, 1'b1, ST_EMPTY);
      end else begin
         for (int k = 0; k < int'(size); k++) begin
            pool[k] = ELEM_W'(k);
         end
         rest = {2'b00, rank};
         for (remaining = int'(size); remaining > 0; remaining--) begin
            weight = factorial(remaining - 1);
            digit  = rest / weight;
            rest   = rest % weight;
            if (digit >= 64'(remaining)) begin
               digit = 64'(remaining - 1);
            end
            pick = int'(digit);
            push_result(pool[pick], remaining == 1, ST_OK);
            for (int k = pick; k + 1 < remaining; k++) begin
               pool[k] = pool[k + 1];
            end
         end
      end
   endfunction

   // predict on each request transaction, compare on each response transaction
   always @(posedge clock) begin
      perm_result_type got;
      perm_result_type want;
      if (reset) begin
         awaited_q.delete();
      end else begin
         if (req.valid && req.ready) begin
            unrank_into(req.rank, req.size);
         end
         if (rsp.valid && rsp.ready) begin
            got.element = rsp.element;
            got.last    = rsp.last;
            got.status  = rsp.status;
            if (awaited_q.size() == 0) begin
               $error("response with nothing outstanding: element %0d last %0d status %0d",
                      got.element, got.last, got.status);
               failures++;
            end else begin
               want = awaited_q.pop_front();
               checked++;
               if (want.status != ST_OK) begin
                  specials++;
               end
               if (got.element !== want.element) begin
                  $error("element: expected %0d, actual %0d", want.element, got.element);
                  failures++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, got.last);
                  failures++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  failures++;
               end
            end
         end
      end
      fail_count   <= failures;
      pending      <= awaited_q.size();
      results_seen <= checked;
      special_seen <= specials;
   end

endmodule

/* tb/sv/permutation_unrank_tb.sv */
module permutation_unrank_tb;
   import perm_unrk_pkg::*;

   localparam int MAX_SIZE      = 20;
   localparam int ITEMS_PER_MIX = 108;
   localparam int STALL_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 100;

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   items_sent;
   int   quiet_cycles;
   int   fail_count;
   int   pending;
   int   results_seen;
   int   special_seen;

   perm_unrk_req_if req_ch ();
   perm_unrk_rsp_if rsp_ch ();

   permutation_unrank #(.MAX_SIZE(MAX_SIZE)) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   permutation_unrank_checker #(.MAX_SIZE(MAX_SIZE)) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .fail_count   (fail_count),
      .pending      (pending),
      .results_seen (results_seen),
      .special_seen (special_seen)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // consumer backpressure
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // watchdog: give up when no transaction moves for too long
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("simulation failed");
      $finish;
   end

   function automatic logic [63:0] fact_of(input int n);
      logic [63:0] f;
      f = 64'd1;
      for (int k = 2; k <= n; k++) begin
         f = f * 64'(k);
      end
      return f;
   endfunction

   // one request transaction, with an optional random idle gap ahead of it
   task automatic send_request(input logic [RANK_W-1:0] rank, input logic [SIZE_W-1:0] size);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(0, 99) < idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.rank  <= rank;
      req_ch.size  <= size;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      items_sent++;
   endtask

   // mostly in-range ranks, some boundary ranks, the rest unconstrained noise
   task automatic send_random;
      logic [63:0] wide;
      logic [63:0] limit;
      int          n;
      int          pick;
      pick = $urandom_range(0, 99);
      wide = {$urandom, $urandom};
      if (pick < 70) begin
         n = $urandom_range(1, MAX_SIZE);
         send_request(RANK_W'(wide % fact_of(n)), SIZE_W'(n));
      end else if (pick < 82) begin
         n     = $urandom_range(0, MAX_SIZE);
         limit = fact_of(n);
         case ($urandom_range(0, 2))
            0:       send_request('0, SIZE_W'(n));
            1:       send_request(RANK_W'(limit - 64'd1), SIZE_W'(n));
            default: send_request(RANK_W'(limit), SIZE_W'(n));
         endcase
      end else begin
         n = $urandom_range(0, 31);
         send_request(RANK_W'(wide >> $urandom_range(0, 63)), SIZE_W'(n));
      end
   endtask

   // hold the sender until every outstanding element has come back
   task automatic wait_drained;
      req_ch.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending != 0);
   endtask

   initial begin
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.rank  <= '0;
      req_ch.size  <= '0;
      idle_pct     = 0;
      stall_pct    <= 0;
      items_sent   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty and out-of-range corners, smallest and largest sizes
      send_request('0, 5'd0);
      send_request(62'd1, 5'd0);
      send_request('1, 5'd0);
      send_request('0, 5'd1);
      send_request(62'd1, 5'd1);
      send_request(62'd1, 5'd2);
      send_request(62'd2, 5'd2);
      for (int r = 0; r < 6; r++) begin
         send_request(RANK_W'(r), 5'd3);
      end
      send_request(62'd119, 5'd5);
      send_request(62'd120, 5'd5);
      send_request('0, 5'd20);
      send_request(RANK_W'(fact_of(20) - 64'd1), 5'd20);
      send_request(RANK_W'(fact_of(20)), 5'd20);
      send_request('1, 5'd20);
      send_request(RANK_W'(fact_of(19) - 64'd1), 5'd19);
      send_request('0, 5'd21);
      send_request('1, 5'd31);
      send_request(62'h2AAA_AAAA_AAAA_AAAA, 5'd20);

      // handshake mixes: free flow, idle sender, stalled receiver, both
      for (int mix = 0; mix < 4; mix++) begin
         case (mix)
            0: begin
               idle_pct  = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct  = 75;
               stall_pct <= 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct <= 75;
            end
            default: begin
               idle_pct  = 28;
               stall_pct <= 28;
            end
         endcase
         repeat (ITEMS_PER_MIX) send_random();
         if (mix == 1) begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests over four handshake mixes, %0d response transactions checked",
               items_sent, results_seen);
      $display("%0d of them empty or out-of-range answers; sizes 0 to 31, full 62-bit ranks",
               special_seen);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
